// ===== design/tccw_pkg.sv =====
// ============================================================================
// Text console cell writer package
// Command codes, controller states and channel payload types used by the
// cell writer and the testbench.
// ============================================================================
`default_nettype none

package tccw_pkg;

  // Field widths of the channel payloads.
  localparam int unsigned OP_W      = 3;
  localparam int unsigned CHAR_W    = 8;
  localparam int unsigned POS_W     = 16;
  localparam int unsigned COL_OUT_W = 6;
  localparam int unsigned ROW_OUT_W = 5;

  // Character codes with a meaning of their own.
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

  typedef enum logic [OP_W-1:0] {
    OP_PRINT      = 3'd0,
    OP_PUT_AT     = 3'd1,
    OP_SET_CURSOR = 3'd2,
    OP_CLEAR      = 3'd3,
    OP_SCROLL_UP  = 3'd4,
    OP_FILL       = 3'd5,
    OP_READ_CELL  = 3'd6
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e               opcode;
    logic [CHAR_W-1:0] char_code;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [POS_W-1:0]  area_width;
    logic [POS_W-1:0]  area_height;
  } cmd_t;

  typedef struct packed {
    logic                 ok;
    logic [COL_OUT_W-1:0] cursor_col;
    logic [ROW_OUT_W-1:0] cursor_row;
    logic [CHAR_W-1:0]    cell_value;
  } res_t;

endpackage

`default_nettype wire

// ===== design/tccw_stream_if.sv =====
// ============================================================================
// Text console stream channel
// Valid/ready channel that carries one payload per transfer.
// ============================================================================
`default_nettype none

interface tccw_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== design/text_console_cell_writer.sv =====
// ============================================================================
// Text console cell writer
// Character buffer of COLS by ROWS byte cells with a cursor, driven by
// commands on a valid/ready channel, one result per command.
// ============================================================================
// Usage:
// Commands arrive on cmd_i and each produces exactly one result on res_o.
// A transfer happens on a rising edge where valid and ready are both high.
// The cells live in one synchronous memory with one write and one read port.
// The controller takes one command at a time: a command is latched, then
// executed against the memory, and its result is loaded into an output
// register. That register decouples the sides: the next command is taken
// while a finished result still waits for the receiver.
// Print, put_at, set_cursor, an off-screen read_cell, an unused code and a
// fill that covers no cell load their result straight from execution. A
// read_cell on screen first waits for the registered memory read data.
// Clear, scroll_up and a fill that covers cells first walk the cells, one
// cell per cycle; a fill walks only its clipped rectangle. The next command
// is taken only once the result of the current one is loaded.
// After reset the cursor is at home and a clearing pass writes spaces to
// every cell, with cmd_i.ready low. When the receiver stalls, a finished
// result holds in the output register; one more command may be taken and
// runs until it has to emit.
// ============================================================================
`default_nettype none

module text_console_cell_writer #(
  parameter int COLS = 40,
  parameter int ROWS = 30
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  tccw_stream_if.sink   cmd_i,
  tccw_stream_if.source res_o
);
  import tccw_pkg::*;

  localparam int CELLS = COLS * ROWS;
  // Cells that take part in the row move of a scroll.
  localparam int MOVE  = COLS * (ROWS - 1);
  localparam int AW    = $clog2(CELLS);
  localparam int SW    = $clog2(CELLS + 1);
  localparam int CW    = $clog2(COLS);
  localparam int RW    = $clog2(ROWS);

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  state_e          state_q, state_d;
  logic [CW-1:0]   cur_col_q, cur_col_d;
  logic [RW-1:0]   cur_row_q, cur_row_d;
  logic [SW-1:0]   scan_q, scan_d;
  logic            init_q, init_d;
  logic            res_valid_q;
  res_t            res_q, res_d;
  cmd_t            cmd_q;

  // Fill walk: first and last column, last row, current position and the
  // address of the first cell of the current row.
  logic [CW-1:0]   fill_x_q, fill_xl_q, fill_col_q;
  logic [RW-1:0]   fill_yl_q, fill_row_q;
  logic [AW-1:0]   fill_base_q;
  logic [CW-1:0]   fill_xl_d;
  logic [RW-1:0]   fill_yl_d;
  logic            fill_ld;

  // Cell memory.
  logic [CHAR_W-1:0] mem_q [CELLS];
  logic [CHAR_W-1:0] mem_rdata_q;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [CHAR_W-1:0] mem_wdata;

  logic            cmd_take;
  logic            res_load;
  logic            out_free;

  // --------------------------------------------------------------------------
  // Command decode
  // --------------------------------------------------------------------------
  logic            is_newline;
  logic            on_screen;
  logic            fill_hit;
  logic            exec_walk;
  logic [CW-1:0]   sel_col;
  logic [RW-1:0]   sel_row;
  logic [AW-1:0]   row_base;
  logic [AW-1:0]   cell_addr;
  logic [CW:0]     col_inc;
  logic            col_wrap;
  logic            row_adv;
  logic [CW-1:0]   pc_col;
  logic [RW-1:0]   pc_row;
  logic [CW-1:0]   clamp_col;
  logic [RW-1:0]   clamp_row;
  logic [POS_W:0]  x_end, y_end;

  always_comb begin
    is_newline = (cmd_q.char_code == NEWLINE_CODE);
    on_screen  = (cmd_q.pos_x < POS_W'(COLS)) && (cmd_q.pos_y < POS_W'(ROWS));
    fill_hit   = on_screen && (cmd_q.area_width != '0) && (cmd_q.area_height != '0);

    // Commands that go on to a cell walk or a memory read before they emit.
    exec_walk  = (cmd_q.opcode == OP_CLEAR) || (cmd_q.opcode == OP_SCROLL_UP) ||
                 ((cmd_q.opcode == OP_FILL) && fill_hit) ||
                 ((cmd_q.opcode == OP_READ_CELL) && on_screen);

    // A print addresses the cursor cell; the others address pos_x, pos_y.
    if (cmd_q.opcode == OP_PRINT) begin
      sel_col = cur_col_q;
      sel_row = cur_row_q;
    end else begin
      sel_col = cmd_q.pos_x[CW-1:0];
      sel_row = cmd_q.pos_y[RW-1:0];
    end
    row_base  = AW'(sel_row) * AW'(COLS);
    cell_addr = row_base + AW'(sel_col);

    // Cursor advance of a print: a newline or a line end moves to the next
    // row, and the row wraps to the top without scrolling.
    col_inc  = {1'b0, cur_col_q} + (CW+1)'(1);
    col_wrap = is_newline || (col_inc == (CW+1)'(COLS));
    pc_col   = col_wrap ? '0 : col_inc[CW-1:0];
    row_adv  = col_wrap;
    if (!row_adv) begin
      pc_row = cur_row_q;
    end else if (cur_row_q == RW'(ROWS - 1)) begin
      pc_row = '0;
    end else begin
      pc_row = cur_row_q + RW'(1);
    end

    clamp_col = (cmd_q.pos_x >= POS_W'(COLS)) ? CW'(COLS - 1) : cmd_q.pos_x[CW-1:0];
    clamp_row = (cmd_q.pos_y >= POS_W'(ROWS)) ? RW'(ROWS - 1) : cmd_q.pos_y[RW-1:0];

    // Fill rectangle, clipped at the right and bottom edges.
    x_end = {1'b0, cmd_q.pos_x} + {1'b0, cmd_q.area_width};
    y_end = {1'b0, cmd_q.pos_y} + {1'b0, cmd_q.area_height};
    fill_xl_d = (x_end > (POS_W+1)'(COLS)) ? CW'(COLS - 1) : CW'(x_end - (POS_W+1)'(1));
    fill_yl_d = (y_end > (POS_W+1)'(ROWS)) ? RW'(ROWS - 1) : RW'(y_end - (POS_W+1)'(1));

    out_free = !res_valid_q || res_o.ready;
  end

  assign cmd_take    = cmd_i.valid && cmd_i.ready;
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign res_o.valid = res_valid_q;
  assign res_o.payload = res_q;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (cmd_i.valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_walk) begin
          case (cmd_q.opcode)
            OP_CLEAR:     state_d = ST_CLEAR;
            OP_SCROLL_UP: state_d = ST_SCROLL;
            OP_FILL:      state_d = ST_FILL;
            default:      state_d = ST_DONE;
          endcase
        end else if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (scan_q == SW'(CELLS - 1)) begin
          state_d = init_q ? ST_IDLE : ST_DONE;
        end
      end
      ST_SCROLL: begin
        if (scan_q == SW'(CELLS)) begin
          state_d = ST_DONE;
        end
      end
      ST_FILL: begin
        if ((fill_col_q == fill_xl_q) && (fill_row_q == fill_yl_q)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Datapath and memory control
  // --------------------------------------------------------------------------
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    scan_d    = scan_q;
    init_d    = init_q;
    fill_ld   = 1'b0;
    res_load  = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = cell_addr;
    mem_raddr = cell_addr;
    mem_wdata = cmd_q.char_code;

    case (state_q)
      ST_EXEC: begin
        case (cmd_q.opcode)
          OP_PRINT: begin
            if (out_free) begin
              mem_we    = !is_newline;
              cur_col_d = pc_col;
              cur_row_d = pc_row;
              res_load  = 1'b1;
            end
          end
          OP_PUT_AT: begin
            if (out_free) begin
              mem_we   = on_screen;
              res_load = 1'b1;
            end
          end
          OP_SET_CURSOR: begin
            if (out_free) begin
              cur_col_d = clamp_col;
              cur_row_d = clamp_row;
              res_load  = 1'b1;
            end
          end
          OP_CLEAR: begin
            scan_d    = '0;
            cur_col_d = '0;
            cur_row_d = '0;
          end
          OP_SCROLL_UP: begin
            scan_d = '0;
          end
          OP_FILL: begin
            if (fill_hit) begin
              fill_ld = 1'b1;
            end else if (out_free) begin
              res_load = 1'b1;
            end
          end
          OP_READ_CELL: begin
            if (on_screen) begin
              mem_re = 1'b1;
            end else if (out_free) begin
              res_load = 1'b1;
            end
          end
          default: begin
            if (out_free) begin
              res_load = 1'b1;
            end
          end
        endcase
      end
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(scan_q);
        mem_wdata = SPACE_CODE;
        scan_d    = scan_q + SW'(1);
        if (scan_q == SW'(CELLS - 1)) begin
          init_d = 1'b0;
        end
      end
      ST_SCROLL: begin
        // Read one row ahead and write the cell behind it in the following cycle;
        // the bottom row is written with spaces at the end of the pass.
        mem_re    = (scan_q < SW'(MOVE));
        mem_raddr = AW'(scan_q + SW'(COLS));
        mem_we    = (scan_q != '0);
        mem_waddr = AW'(scan_q - SW'(1));
        mem_wdata = (scan_q <= SW'(MOVE)) ? mem_rdata_q : SPACE_CODE;
        scan_d    = scan_q + SW'(1);
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_base_q + AW'(fill_col_q);
      end
      ST_DONE: begin
        res_load = out_free;
      end
      default: begin
      end
    endcase

    res_d.ok         = !((cmd_q.opcode == OP_READ_CELL) && !on_screen);
    res_d.cursor_col = COL_OUT_W'(cur_col_d);
    res_d.cursor_row = ROW_OUT_W'(cur_row_d);
    res_d.cell_value = ((state_q == ST_DONE) && (cmd_q.opcode == OP_READ_CELL)) ?
                       mem_rdata_q : '0;
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      scan_q      <= '0;
      init_q      <= 1'b1;
      res_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      scan_q    <= scan_d;
      init_q    <= init_d;
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (cmd_take) begin
      cmd_q <= cmd_i.payload;
    end
    if (res_load) begin
      res_q <= res_d;
    end
    if (fill_ld) begin
      fill_x_q    <= cmd_q.pos_x[CW-1:0];
      fill_xl_q   <= fill_xl_d;
      fill_yl_q   <= fill_yl_d;
      fill_col_q  <= cmd_q.pos_x[CW-1:0];
      fill_row_q  <= cmd_q.pos_y[RW-1:0];
      fill_base_q <= row_base;
    end else if (state_q == ST_FILL) begin
      if (fill_col_q == fill_xl_q) begin
        fill_col_q  <= fill_x_q;
        fill_row_q  <= fill_row_q + RW'(1);
        fill_base_q <= fill_base_q + AW'(COLS);
      end else begin
        fill_col_q <= fill_col_q + CW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cell memory: one write port, one read port with registered data
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_q <= mem_q[mem_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // Every cell write lands inside the buffer.
  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (32'(mem_waddr) < CELLS))
    else $error("cell write outside the buffer");

  // A result is never loaded over one the receiver has not taken.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!res_valid_q || res_o.ready))
    else $error("result register overwritten");

  // The cursor always stays on the screen.
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (32'(cur_col_q) < COLS) && (32'(cur_row_q) < ROWS))
    else $error("cursor left the screen");

  // No command is taken while the reset clearing pass is running.
  a_init_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |-> !cmd_take)
    else $error("command taken during the clearing pass");

  // The clearing pass after reset produces no result.
  a_init_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    init_q |=> !$rose(res_valid_q))
    else $error("result produced by the reset clearing pass");

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
// ============================================================================
// Text console cell writer testbench
// Drives commands into the cell writer and checks each result against a
// shadow copy of the screen and cursor kept inside the bench. A short
// directed part is followed by random command traffic. Both sides idle at
// random, and the receiver holds off once so that the block backs up.
// ============================================================================
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tccw_pkg::*;

  localparam int unsigned COLS  = 40;
  localparam int unsigned ROWS  = 30;
  localparam int unsigned CELLS = COLS * ROWS;

  // Opcode 7 is not part of the command set and must be a no-op.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam int unsigned RANDOM_ITEMS = 775;
  localparam int unsigned IDLE_PCT     = 31;
  localparam int unsigned HOLD_CYCLES  = 250;
  localparam int unsigned DRAIN_LIMIT  = 20000;

  // ---------------------------------------------------------------------------
  // Shadow of the screen and cursor. Every accepted command is applied here,
  // and the status it should produce is queued until the block returns it.
  // ---------------------------------------------------------------------------
  class console_shadow;
    logic [CHAR_W-1:0] screen [CELLS];
    int unsigned       col;
    int unsigned       row;
    res_t              awaited_status [$];
    int unsigned       mismatches;
    int unsigned       compared;

    function new();
      blank_screen();
      col        = 0;
      row        = 0;
      mismatches = 0;
      compared   = 0;
    endfunction

    function void blank_screen();
      foreach (screen[i]) screen[i] = SPACE_CODE;
    endfunction

    function void poke(int unsigned x, int unsigned y, logic [CHAR_W-1:0] ch);
      if (x < COLS && y < ROWS) screen[y * COLS + x] = ch;
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
    endtask

    // Apply one accepted command and queue the status it should report.
    function void apply_command(cmd_t c);
      res_t        exp_status;
      int unsigned x_end;
      int unsigned y_end;
      exp_status = '0;
      exp_status.ok = 1'b1;
      case (c.opcode)
        OP_PRINT: begin
          if (c.char_code == NEWLINE_CODE) begin
            // A newline writes no cell; it starts the next line.
            col = 0;
            row++;
          end else if (col < COLS && row < ROWS) begin
            poke(col, row, c.char_code);
            col++;
          end
          // Line end wraps to the next row, and the bottom wraps to the top.
          if (col >= COLS) begin
            col = 0;
            row++;
          end
          if (row >= ROWS) row = 0;
        end
        OP_PUT_AT: poke(32'(c.pos_x), 32'(c.pos_y), c.char_code);
        OP_SET_CURSOR: begin
          col = (c.pos_x >= COLS) ? COLS - 1 : 32'(c.pos_x);
          row = (c.pos_y >= ROWS) ? ROWS - 1 : 32'(c.pos_y);
        end
        OP_CLEAR: begin
          blank_screen();
          col = 0;
          row = 0;
        end
        OP_SCROLL_UP: begin
          for (int unsigned i = 0; i < CELLS - COLS; i++) screen[i] = screen[i + COLS];
          for (int unsigned i = CELLS - COLS; i < CELLS; i++) screen[i] = SPACE_CODE;
        end
        OP_FILL: begin
          x_end = 32'(c.pos_x) + 32'(c.area_width);
          y_end = 32'(c.pos_y) + 32'(c.area_height);
          if (x_end > COLS) x_end = COLS;
          if (y_end > ROWS) y_end = ROWS;
          for (int unsigned r = 32'(c.pos_y); r < y_end; r++) begin
            for (int unsigned k = 32'(c.pos_x); k < x_end; k++) poke(k, r, c.char_code);
          end
        end
        OP_READ_CELL: begin
          if (c.pos_x < COLS && c.pos_y < ROWS) begin
            exp_status.cell_value = screen[c.pos_y * COLS + c.pos_x];
          end else begin
            exp_status.ok = 1'b0;
          end
        end
        default: begin
        end
      endcase
      exp_status.cursor_col = col[COL_OUT_W-1:0];
      exp_status.cursor_row = row[ROW_OUT_W-1:0];
      awaited_status.push_back(exp_status);
    endfunction

    // Compare one returned status with the oldest one still awaited.
    task compare_status(res_t got);
      res_t exp_status;
      if (awaited_status.size() == 0) begin
        report_mismatch($sformatf("result with nothing awaited: %p", got));
        return;
      end
      exp_status = awaited_status.pop_front();
      compared++;
      if (got.ok !== exp_status.ok)
        report_mismatch($sformatf("result %0d ok: got %b, expected %b",
                                  compared, got.ok, exp_status.ok));
      if (got.cursor_col !== exp_status.cursor_col)
        report_mismatch($sformatf("result %0d cursor_col: got %0d, expected %0d",
                                  compared, got.cursor_col, exp_status.cursor_col));
      if (got.cursor_row !== exp_status.cursor_row)
        report_mismatch($sformatf("result %0d cursor_row: got %0d, expected %0d",
                                  compared, got.cursor_row, exp_status.cursor_row));
      if (got.cell_value !== exp_status.cell_value)
        report_mismatch($sformatf("result %0d cell_value: got %0d, expected %0d",
                                  compared, got.cell_value, exp_status.cell_value));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and channels.
  // ---------------------------------------------------------------------------
  logic clk_i;
  logic rst_ni;

  // Flags shared between processes are changed with nonblocking assignments
  // after their initial values, so every reader sees a settled value at the clock edge.
  logic no_idle;
  logic hold_req;
  logic hold_res;

  tccw_stream_if #(.T(cmd_t)) cmd_if ();
  tccw_stream_if #(.T(res_t)) res_if ();

  text_console_cell_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if.sink),
    .res_o (res_if.source)
  );

  console_shadow console;
  int unsigned   op_count [8];

  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Command side.
  // ---------------------------------------------------------------------------
  function automatic cmd_t make_cmd(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                    logic [POS_W-1:0] x, logic [POS_W-1:0] y,
                                    logic [POS_W-1:0] w, logic [POS_W-1:0] h);
    cmd_t c;
    c.opcode      = op_e'(op);
    c.char_code   = ch;
    c.pos_x       = x;
    c.pos_y       = y;
    c.area_width  = w;
    c.area_height = h;
    return c;
  endfunction

  // Offer one command, with random idle cycles in front unless idling is
  // switched off, and hold it until the block takes it. Valid stays high
  // after the transfer so that back-to-back commands follow without valid dropping.
  task automatic send_command(input cmd_t c);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= c;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    console.apply_command(c);
    op_count[c.opcode]++;
  endtask

  // Random command mix. Most traffic is printing, placing and reading cells,
  // since that is where the cursor walks through line end and bottom wrap.
  // The slow whole-screen commands are kept rare, and most fills are small.
  // Unused fields are random over their full width so every bit toggles.
  function automatic cmd_t random_command();
    cmd_t        c;
    int unsigned pick;
    int unsigned flavor;
    pick   = $urandom_range(99);
    flavor = $urandom_range(99);
    c = make_cmd(OP_PRINT, CHAR_W'($urandom_range(255)),
                 POS_W'($urandom_range(65535)), POS_W'($urandom_range(65535)),
                 POS_W'($urandom_range(65535)), POS_W'($urandom_range(65535)));
    if (pick < 40) begin
      c.opcode = OP_PRINT;
      if (flavor < 12) c.char_code = NEWLINE_CODE;
    end else if (pick < 55) begin
      c.opcode = OP_PUT_AT;
      if (flavor >= 15) begin
        c.pos_x = POS_W'($urandom_range(COLS - 1));
        c.pos_y = POS_W'($urandom_range(ROWS - 1));
      end
    end else if (pick < 62) begin
      c.opcode = OP_SET_CURSOR;
      if (flavor >= 20) begin
        c.pos_x = POS_W'($urandom_range(COLS));
        c.pos_y = POS_W'($urandom_range(ROWS));
      end
    end else if (pick < 80) begin
      c.opcode = OP_READ_CELL;
      if (flavor >= 12) begin
        c.pos_x = POS_W'($urandom_range(COLS - 1));
        c.pos_y = POS_W'($urandom_range(ROWS - 1));
      end
    end else if (pick < 84) begin
      c.opcode = OP_FILL;
      if (flavor >= 12) begin
        c.pos_x       = POS_W'($urandom_range(COLS + 1));
        c.pos_y       = POS_W'($urandom_range(ROWS + 1));
        c.area_width  = POS_W'($urandom_range(6));
        c.area_height = POS_W'($urandom_range(6));
      end else if (flavor >= 6) begin
        // Large rectangle that runs past the right and bottom edges.
        c.pos_x = POS_W'($urandom_range(COLS - 1));
        c.pos_y = POS_W'($urandom_range(ROWS - 1));
      end
    end else if (pick < 86) begin
      c.opcode = OP_CLEAR;
    end else if (pick < 88) begin
      c.opcode = OP_SCROLL_UP;
    end else if (pick < 90) begin
      c.opcode = op_e'(OP_UNUSED);
    end else begin
      // Printable text keeps the cursor moving along the lines.
      c.opcode    = OP_PRINT;
      c.char_code = CHAR_W'($urandom_range(8'h20, 8'h7e));
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: the receiver idles at random, stops entirely while a
  // hold-off is running, and is always ready during the no-idle stretch.
  // ---------------------------------------------------------------------------
  initial begin
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_res) begin
        res_if.ready <= 1'b0;
      end else if (no_idle) begin
        res_if.ready <= 1'b1;
      end else begin
        res_if.ready <= ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Hold-off: once requested, the receiver refuses results until the hold-off
  // ends while commands keep coming, so the result register fills, the next
  // command finishes behind it, and the block has to drop cmd ready.
  initial begin
    hold_res = 1'b0;
    do @(posedge clk_i); while (!hold_req);
    hold_res <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_res <= 1'b0;
  end

  // Every result transfer is checked at the edge that completes it.
  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) console.compare_status(res_if.payload);
  end

  // Overall time limit, far beyond the slowest correct run.
  initial begin
    #50ms;
    $display("text_console_cell_writer verification failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned drain_cycles;
    console        = new();
    rst_ni         = 1'b0;
    no_idle        = 1'b0;
    hold_req       = 1'b0;
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    foreach (op_count[i]) op_count[i] = 0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. The block runs a clearing pass after reset; the first
    // command simply waits for the handshake.
    send_command(make_cmd(OP_PRINT, 8'h48, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_cmd(OP_PRINT, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_command(make_cmd(OP_PRINT, 8'h00, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_cmd(OP_PRINT, NEWLINE_CODE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    // Cell writes at both corners, then three that fall off the screen.
    send_command(make_cmd(OP_PUT_AT, 8'h55, 16'd0, 16'd0, 16'd0, 16'd0));
    send_command(make_cmd(OP_PUT_AT, 8'haa, POS_W'(COLS - 1), POS_W'(ROWS - 1),
                          16'd0, 16'd0));
    send_command(make_cmd(OP_PUT_AT, 8'h21, POS_W'(COLS), 16'd0, 16'd0, 16'd0));
    send_command(make_cmd(OP_PUT_AT, 8'h22, 16'd0, POS_W'(ROWS), 16'd0, 16'd0));
    send_command(make_cmd(OP_PUT_AT, 8'h23, 16'hffff, 16'hffff, 16'd0, 16'd0));
    // Reads on the screen, just past the right edge and far off the screen.
    send_command(make_cmd(OP_READ_CELL, 8'h00, POS_W'(COLS - 1), POS_W'(ROWS - 1),
                          16'd0, 16'd0));
    send_command(make_cmd(OP_READ_CELL, 8'h00, POS_W'(COLS), 16'd0, 16'd0, 16'd0));
    send_command(make_cmd(OP_READ_CELL, 8'h00, 16'hffff, 16'hffff, 16'd0, 16'd0));
    // Cursor clamping, then a character at the last cell wraps line and screen.
    send_command(make_cmd(OP_SET_CURSOR, 8'h00, 16'hffff, 16'hffff, 16'd0, 16'd0));
    send_command(make_cmd(OP_PRINT, 8'h5a, 16'd0, 16'd0, 16'd0, 16'd0));
    // A newline on the bottom row wraps to the top.
    send_command(make_cmd(OP_SET_CURSOR, 8'h00, 16'd5, POS_W'(ROWS - 1), 16'd0, 16'd0));
    send_command(make_cmd(OP_PRINT, NEWLINE_CODE, 16'd0, 16'd0, 16'd0, 16'd0));
    // Fills: clipped at both edges, zero width, zero height, off screen, inside.
    send_command(make_cmd(OP_FILL, 8'h23, POS_W'(COLS - 2), POS_W'(ROWS - 2),
                          16'hffff, 16'hffff));
    send_command(make_cmd(OP_FILL, 8'h24, 16'd0, 16'd0, 16'd0, 16'd5));
    send_command(make_cmd(OP_FILL, 8'h25, 16'd0, 16'd0, 16'd5, 16'd0));
    send_command(make_cmd(OP_FILL, 8'h26, POS_W'(COLS), 16'd0, 16'd3, 16'd3));
    send_command(make_cmd(OP_FILL, 8'h2a, 16'd2, 16'd3, 16'd4, 16'd2));
    // Scroll keeps the cursor; the filled corner moves up one row.
    send_command(make_cmd(OP_SCROLL_UP, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0));
    send_command(make_cmd(OP_READ_CELL, 8'h00, POS_W'(COLS - 1), POS_W'(ROWS - 2),
                          16'd0, 16'd0));
    send_command(make_cmd(OP_UNUSED, 8'hff, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_command(make_cmd(OP_CLEAR, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0));
    send_command(make_cmd(OP_READ_CELL, 8'h00, 16'd0, 16'd0, 16'd0, 16'd0));

    // Random part, with a stretch where neither side idles and, later, one
    // long receiver hold-off while commands keep being offered.
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 200) no_idle <= 1'b1;
      if (n == 350) no_idle <= 1'b0;
      if (n == 600) hold_req <= 1'b1;
      send_command(random_command());
    end
    cmd_if.valid <= 1'b0;

    // Wait for every awaited result, then keep the clock running so that a
    // stray extra result would still be caught.
    drain_cycles = 0;
    while (console.awaited_status.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    repeat (50) @(posedge clk_i);
    if (console.awaited_status.size() != 0)
      console.report_mismatch($sformatf("%0d results never arrived",
                                        console.awaited_status.size()));

    $display("Run covered %0d print, %0d put_at, %0d set_cursor, %0d clear, %0d scroll_up,",
             op_count[OP_PRINT], op_count[OP_PUT_AT], op_count[OP_SET_CURSOR],
             op_count[OP_CLEAR], op_count[OP_SCROLL_UP]);
    $display("%0d fill, %0d read_cell and %0d unused-code commands; %0d results compared.",
             op_count[OP_FILL], op_count[OP_READ_CELL], op_count[OP_UNUSED],
             console.compared);
    if (console.mismatches == 0) begin
      $display("text_console_cell_writer verification clean");
    end else begin
      $display("text_console_cell_writer verification failed");
    end
    $finish;
  end

endmodule
